>>> design/tmps_pkg.sv
`default_nettype none

package tmps_pkg;

    // Widths fixed by the stream format
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 24;

    // Default depth of the row store
    localparam int MAX_ROWS_DEFAULT = 256;

    // Byte-aligned width of the result tdata
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Position of a cell within its row, chooses the parent it extends
    typedef enum logic [1:0] {
        POS_APEX  = 2'd0,
        POS_FIRST = 2'd1,
        POS_MID   = 2'd2,
        POS_LAST  = 2'd3
    } pos_t;

endpackage

`default_nettype wire

>>> design/triangle_min_path_sum.sv
// Triangle minimum path sum over a stream of elements.
//
// Slave channel: one triangle element per transaction, in row-major order
// (row r carries r+1 elements). s_tdata holds the signed element, s_tlast
// marks the final element of the triangle.
// Master channel: one transaction per triangle, issued for the element that
// carried s_tlast. m_tdata holds the signed minimum path sum (saturated to
// 24 bits), m_tuser is set if the triangle had more rows than MAX_ROWS; the
// extra rows are then dropped and the sum covers the first MAX_ROWS rows.
//
// Throughput: one element per cycle unless a last element stalls. Each element
// passes an input register, one add/compare against the stored row entry, and
// the row store write; the store read for the next column is issued in the same
// cycle. The last element passes the input register, then the result register.
// Stalls: while m_tready is low and a result waits, a further last element holds
// in the input register and s_tready drops; ordinary elements keep flowing.
// Reset (aresetn low, synchronous): empty both registers and start a new
// triangle. The row store needs no clearing; it is written before it is read.

`default_nettype none

module triangle_min_path_sum #(
    parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: [15:0] value
    input  wire logic [tmps_pkg::VALUE_W-1:0]       s_tdata,
    input  wire logic                               s_tlast,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // m_tdata: [23:0] min_total
    output logic [tmps_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // m_tuser: [0] row_overflow
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready
);
    import tmps_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Input register
    logic                     in_valid_reg, in_valid_next;
    logic signed [VALUE_W-1:0] in_value_reg;
    logic                     in_last_reg;

    // Triangle state
    logic [ROW_W-1:0]        row_index_reg, row_index_next;
    logic [ADDR_W-1:0]       col_index_reg, col_index_next;
    logic signed [SUM_W-1:0] left_parent_reg, left_parent_next;
    logic signed [SUM_W-1:0] running_min_reg, running_min_next;
    logic                    overflow_reg, overflow_next;

    // Row store and its registered read port
    logic signed [SUM_W-1:0] row_sums_mem [MAX_ROWS];
    logic signed [SUM_W-1:0] rd_data_reg;
    logic                    wr_en;

    // Result register
    logic                    m_valid_reg, m_valid_next;
    logic signed [SUM_W-1:0] min_total_reg, min_total_next;
    logic                    row_ovf_reg, row_ovf_next;

    logic                    fire;
    logic                    active;
    logic                    row_end;
    logic [ROW_W-1:0]        col_ext;
    pos_t                    pos;
    logic signed [SUM_W-1:0] cell_sum;

    // Process the held element unless it is a last one and the result slot is blocked
    assign fire     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign col_ext = ROW_W'(col_index_reg);
    assign active  = row_index_reg < ROW_W'(MAX_ROWS);
    assign row_end = col_ext >= row_index_reg;

    always_comb begin
        if (row_index_reg == '0) begin
            pos = POS_APEX;
        end else if (col_index_reg == '0) begin
            pos = POS_FIRST;
        end else if (!row_end) begin
            pos = POS_MID;
        end else begin
            pos = POS_LAST;
        end
    end

    // rd_data_reg always mirrors the stored sum at col_index_reg
    tmps_cell u_cell (
        .value        (in_value_reg),
        .left_parent  (left_parent_reg),
        .right_parent (rd_data_reg),
        .pos          (pos),
        .sum          (cell_sum)
    );

    always_comb begin
        in_valid_next    = in_valid_reg;
        row_index_next   = row_index_reg;
        col_index_next   = col_index_reg;
        left_parent_next = left_parent_reg;
        running_min_next = running_min_reg;
        overflow_next    = overflow_reg;
        min_total_next   = min_total_reg;
        row_ovf_next     = row_ovf_reg;
        m_valid_next     = m_valid_reg;
        wr_en            = 1'b0;

        // Retire a result the receiver has taken
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (fire) begin
            in_valid_next = 1'b0;
            if (active) begin
                wr_en = 1'b1;
                if (col_index_reg == '0 || cell_sum < running_min_reg) begin
                    running_min_next = cell_sum;
                end
                if (pos == POS_FIRST || pos == POS_MID) begin
                    left_parent_next = rd_data_reg;
                end
                if (row_end) begin
                    row_index_next = row_index_reg + ROW_W'(1);
                    col_index_next = '0;
                end else begin
                    col_index_next = col_index_reg + ADDR_W'(1);
                end
            end else begin
                // Rows beyond the store: drop the element, flag the triangle
                overflow_next = 1'b1;
            end

            if (in_last_reg) begin
                min_total_next   = running_min_next;
                row_ovf_next     = overflow_next;
                m_valid_next     = 1'b1;
                row_index_next   = '0;
                col_index_next   = '0;
                left_parent_next = '0;
                running_min_next = '0;
                overflow_next    = 1'b0;
            end
        end

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            row_index_reg   <= '0;
            col_index_reg   <= '0;
            left_parent_reg <= '0;
            running_min_reg <= '0;
            overflow_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            row_index_reg   <= row_index_next;
            col_index_reg   <= col_index_next;
            left_parent_reg <= left_parent_next;
            running_min_reg <= running_min_next;
            overflow_reg    <= overflow_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
        min_total_reg <= min_total_next;
        row_ovf_reg   <= row_ovf_next;
    end

    // Row store: write the new sum, prefetch the entry for the next column.
    // Forward the write when both hit the same entry (a one-cell row).
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_sums_mem[col_index_reg] <= cell_sum;
        end
        if (wr_en && col_index_reg == col_index_next) begin
            rd_data_reg <= cell_sum;
        end else begin
            rd_data_reg <= row_sums_mem[col_index_next];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = min_total_reg;
    assign m_tuser  = row_ovf_reg;

    // The column never runs past the current row
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        active |-> col_ext <= row_index_reg)
        else $error("column index beyond current row");

    // Once the store is full, the column stays parked at zero
    a_col_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        !active |-> col_index_reg == '0)
        else $error("column index moved after row store filled");

    // A processed last element always yields a result
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> m_valid_reg)
        else $error("last element processed without a result");

    // Input is refused only while an element is held and blocked
    a_ready_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && in_last_reg && m_valid_reg && !m_tready)
        else $error("input stalled without cause");

endmodule

`default_nettype wire

>>> design/tmps_cell.sv
`default_nettype none

module tmps_cell (
    input  wire logic signed [tmps_pkg::VALUE_W-1:0] value,
    input  wire logic signed [tmps_pkg::SUM_W-1:0]   left_parent,
    input  wire logic signed [tmps_pkg::SUM_W-1:0]   right_parent,
    input  wire tmps_pkg::pos_t                      pos,
    output logic signed [tmps_pkg::SUM_W-1:0]        sum
);
    import tmps_pkg::*;

    logic signed [SUM_W-1:0] parent;
    logic signed [SUM_W:0]   wide;

    always_comb begin
        case (pos)
            POS_APEX:  parent = '0;
            POS_FIRST: parent = right_parent;
            POS_MID:   parent = (left_parent < right_parent) ? left_parent : right_parent;
            POS_LAST:  parent = left_parent;
            default:   parent = '0;
        endcase
    end

    // Add in one extra bit, then clamp to the signed sum range
    assign wide = (SUM_W+1)'(parent) + (SUM_W+1)'(value);

    always_comb begin
        if (wide > (SUM_W+1)'(SUM_MAX)) begin
            sum = SUM_MAX;
        end else if (wide < (SUM_W+1)'(SUM_MIN)) begin
            sum = SUM_MIN;
        end else begin
            sum = wide[SUM_W-1:0];
        end
    end

endmodule

`default_nettype wire
